@@ rtl/cext_pkg.sv @@
`default_nettype none

package cext_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned HalfWidth = 16;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned RegIdxWidth = 4;
    localparam int unsigned CodeWidth = 4;
    localparam int unsigned RotWidth = 2;
    localparam int unsigned PipeDepth = 3;

    typedef enum logic [CodeWidth-1:0] {
        FUNC_SXTAB16 = 4'd0,
        FUNC_UXTAB16 = 4'd1,
        FUNC_SXTB16  = 4'd2,
        FUNC_UXTB16  = 4'd3,
        FUNC_SXTAB   = 4'd4,
        FUNC_UXTAB   = 4'd5,
        FUNC_SXTB    = 4'd6,
        FUNC_UXTB    = 4'd7,
        FUNC_SXTAH   = 4'd8,
        FUNC_UXTAH   = 4'd9,
        FUNC_SXTH    = 4'd10,
        FUNC_UXTH    = 4'd11
    } func_t;

    typedef enum logic [CodeWidth-1:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_HS = 4'd2,
        COND_LO = 4'd3,
        COND_MI = 4'd4,
        COND_PL = 4'd5,
        COND_VS = 4'd6,
        COND_VC = 4'd7,
        COND_HI = 4'd8,
        COND_LS = 4'd9,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13,
        COND_AL = 4'd14,
        COND_NV = 4'd15
    } cond_t;

    typedef enum logic [RotWidth-1:0] {
        ROT_0  = 2'd0,
        ROT_8  = 2'd1,
        ROT_16 = 2'd2,
        ROT_24 = 2'd3
    } rot_t;

    typedef struct packed {
        logic [CodeWidth-1:0]   func;
        logic [CodeWidth-1:0]   cond_code;
        logic                   flag_n;
        logic                   flag_z;
        logic                   flag_c;
        logic                   flag_v;
        logic [DataWidth-1:0]   rm_value;
        logic [DataWidth-1:0]   rn_value;
        logic [RotWidth-1:0]    rot_sel;
        logic [RegIdxWidth-1:0] dest_index;
    } cmd_t;

    typedef struct packed {
        logic [DataWidth-1:0]   result_value;
        logic [RegIdxWidth-1:0] result_dest;
        logic                   write_enable;
    } result_t;

    typedef struct packed {
        logic                   valid;
        logic                   pass;
        logic [CodeWidth-1:0]   func;
        logic [DataWidth-1:0]   rot_value;
        logic [DataWidth-1:0]   rn_value;
        logic [RegIdxWidth-1:0] dest;
    } decode_stage_t;

    typedef struct packed {
        logic                   valid;
        logic                   write_enable;
        logic                   dual;
        logic [DataWidth-1:0]   operand_a;
        logic [DataWidth-1:0]   operand_b;
        logic [RegIdxWidth-1:0] dest;
    } extend_stage_t;

endpackage

`default_nettype wire

@@ rtl/conditional_extend_unit.sv @@
// An accepted transaction passes through the decode, extend and accumulate registers in order,
// and result_valid rises together with the result once the accumulate register holds it.
// Throughput: one transaction per cycle through three register stages
// (condition and rotate, extend, add); busy is always low since the receiver cannot stall.
// Reset: rst_n clears every stage valid bit asynchronously; data registers are not reset.
`default_nettype none

module conditional_extend_unit (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    output logic                     busy,
    input  wire cext_pkg::cmd_t      cmd,
    output logic                     result_valid,
    output cext_pkg::result_t        result
);
    import cext_pkg::*;

    logic          accept;
    decode_stage_t decode_stage;
    extend_stage_t extend_stage;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    cext_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .cmd      (cmd),
        .stage    (decode_stage)
    );

    cext_extend u_extend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stage  (decode_stage),
        .out_stage (extend_stage)
    );

    cext_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_stage     (extend_stage),
        .result_valid (result_valid),
        .result       (result)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 result_valid)
        else $error("Accepted transaction did not complete in three cycles.");

    a_never_cond: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.cond_code == COND_NV)) |-> ##3 !result.write_enable)
        else $error("Never condition produced a write.");

    a_dest_passes: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 (result.result_dest == $past(cmd.dest_index, 3)))
        else $error("Destination index changed through the pipeline.");

endmodule

`default_nettype wire

@@ rtl/cext_decode.sv @@
`default_nettype none

module cext_decode (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    input  wire cext_pkg::cmd_t     cmd,
    output cext_pkg::decode_stage_t stage
);
    import cext_pkg::*;

    logic                 cond_ok;
    logic                 func_ok;
    logic [DataWidth-1:0] rot_value;
    logic                 valid_reg;
    logic                 valid_next;
    decode_stage_t        data_reg;
    decode_stage_t        data_next;

    always_comb
    begin
        unique case (cmd.cond_code)
            COND_EQ: cond_ok = cmd.flag_z;
            COND_NE: cond_ok = !cmd.flag_z;
            COND_HS: cond_ok = cmd.flag_c;
            COND_LO: cond_ok = !cmd.flag_c;
            COND_MI: cond_ok = cmd.flag_n;
            COND_PL: cond_ok = !cmd.flag_n;
            COND_VS: cond_ok = cmd.flag_v;
            COND_VC: cond_ok = !cmd.flag_v;
            COND_HI: cond_ok = cmd.flag_c && !cmd.flag_z;
            COND_LS: cond_ok = !cmd.flag_c || cmd.flag_z;
            COND_GE: cond_ok = (cmd.flag_n == cmd.flag_v);
            COND_LT: cond_ok = (cmd.flag_n != cmd.flag_v);
            COND_GT: cond_ok = !cmd.flag_z && (cmd.flag_n == cmd.flag_v);
            COND_LE: cond_ok = cmd.flag_z || (cmd.flag_n != cmd.flag_v);
            COND_AL: cond_ok = 1'b1;
            default: cond_ok = 1'b0;
        endcase
    end

    assign func_ok = (cmd.func <= FUNC_UXTH);

    always_comb
    begin
        unique case (cmd.rot_sel)
            ROT_0:   rot_value = cmd.rm_value;
            ROT_8:   rot_value = {cmd.rm_value[7:0], cmd.rm_value[31:8]};
            ROT_16:  rot_value = {cmd.rm_value[15:0], cmd.rm_value[31:16]};
            default: rot_value = {cmd.rm_value[23:0], cmd.rm_value[31:24]};
        endcase
    end

    always_comb
    begin
        valid_next          = in_valid;
        data_next.valid     = in_valid;
        data_next.pass      = cond_ok && func_ok;
        data_next.func      = cmd.func;
        data_next.rot_value = rot_value;
        data_next.rn_value  = cmd.rn_value;
        data_next.dest      = cmd.dest_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        stage       = data_reg;
        stage.valid = valid_reg;
    end

endmodule

`default_nettype wire

@@ rtl/cext_extend.sv @@
`default_nettype none

module cext_extend (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire cext_pkg::decode_stage_t in_stage,
    output cext_pkg::extend_stage_t      out_stage
);
    import cext_pkg::*;

    logic [ByteWidth-1:0] byte0;
    logic [ByteWidth-1:0] byte2;
    logic [HalfWidth-1:0] half0;
    logic [DataWidth-1:0] operand_a;
    logic                 accumulate;
    logic                 dual;
    logic                 valid_reg;
    logic                 valid_next;
    extend_stage_t        data_reg;
    extend_stage_t        data_next;

    assign byte0 = in_stage.rot_value[7:0];
    assign byte2 = in_stage.rot_value[23:16];
    assign half0 = in_stage.rot_value[15:0];

    always_comb
    begin
        operand_a  = '0;
        accumulate = 1'b0;
        dual       = 1'b0;
        unique case (in_stage.func) inside
            FUNC_SXTAB16, FUNC_SXTB16:
            begin
                operand_a  = {{ByteWidth{byte2[7]}}, byte2, {ByteWidth{byte0[7]}}, byte0};
                dual       = 1'b1;
                accumulate = (in_stage.func == FUNC_SXTAB16);
            end
            FUNC_UXTAB16, FUNC_UXTB16:
            begin
                operand_a  = {{ByteWidth{1'b0}}, byte2, {ByteWidth{1'b0}}, byte0};
                dual       = 1'b1;
                accumulate = (in_stage.func == FUNC_UXTAB16);
            end
            FUNC_SXTAB, FUNC_SXTB:
            begin
                operand_a  = {{(DataWidth-ByteWidth){byte0[7]}}, byte0};
                accumulate = (in_stage.func == FUNC_SXTAB);
            end
            FUNC_UXTAB, FUNC_UXTB:
            begin
                operand_a  = {{(DataWidth-ByteWidth){1'b0}}, byte0};
                accumulate = (in_stage.func == FUNC_UXTAB);
            end
            FUNC_SXTAH, FUNC_SXTH:
            begin
                operand_a  = {{HalfWidth{half0[15]}}, half0};
                accumulate = (in_stage.func == FUNC_SXTAH);
            end
            FUNC_UXTAH, FUNC_UXTH:
            begin
                operand_a  = {{HalfWidth{1'b0}}, half0};
                accumulate = (in_stage.func == FUNC_UXTAH);
            end
            default:
            begin
                operand_a  = '0;
                accumulate = 1'b0;
                dual       = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        valid_next             = in_stage.valid;
        data_next.valid        = in_stage.valid;
        data_next.write_enable = in_stage.pass;
        data_next.dual         = dual;
        data_next.operand_a    = in_stage.pass ? operand_a : '0;
        data_next.operand_b    = (in_stage.pass && accumulate) ? in_stage.rn_value : '0;
        data_next.dest         = in_stage.dest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        out_stage       = data_reg;
        out_stage.valid = valid_reg;
    end

endmodule

`default_nettype wire

@@ rtl/cext_accum.sv @@
`default_nettype none

module cext_accum (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire cext_pkg::extend_stage_t in_stage,
    output logic                         result_valid,
    output cext_pkg::result_t            result
);
    import cext_pkg::*;

    logic [HalfWidth-1:0] sum_lo;
    logic [HalfWidth-1:0] sum_hi;
    logic [DataWidth-1:0] sum_full;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    result_t              result_reg;
    result_t              result_next;

    assign sum_lo   = in_stage.operand_a[15:0] + in_stage.operand_b[15:0];
    assign sum_hi   = in_stage.operand_a[31:16] + in_stage.operand_b[31:16];
    assign sum_full = in_stage.operand_a + in_stage.operand_b;

    always_comb
    begin
        result_valid_next        = in_stage.valid;
        result_next.result_value = in_stage.dual ? {sum_hi, sum_lo} : sum_full;
        result_next.result_dest  = in_stage.dest;
        result_next.write_enable = in_stage.write_enable;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.write_enable) |-> (result.result_value == '0))
        else $error("Failed transaction carries a nonzero result.");

endmodule

`default_nettype wire

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cext_pkg::*;

    localparam int RandomCount = 1700;
    localparam int CycleLimit = 200000;

    class extend_checker;
        result_t expected_results[$];
        int noted;
        int checked;
        int written;
        int failures;

        function new();
            noted = 0;
            checked = 0;
            written = 0;
            failures = 0;
        endfunction

        function bit cond_holds(cmd_t c);
            case (c.cond_code)
                COND_EQ: return c.flag_z;
                COND_NE: return !c.flag_z;
                COND_HS: return c.flag_c;
                COND_LO: return !c.flag_c;
                COND_MI: return c.flag_n;
                COND_PL: return !c.flag_n;
                COND_VS: return c.flag_v;
                COND_VC: return !c.flag_v;
                COND_HI: return c.flag_c && !c.flag_z;
                COND_LS: return !c.flag_c || c.flag_z;
                COND_GE: return c.flag_n == c.flag_v;
                COND_LT: return c.flag_n != c.flag_v;
                COND_GT: return !c.flag_z && (c.flag_n == c.flag_v);
                COND_LE: return c.flag_z || (c.flag_n != c.flag_v);
                COND_AL: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function result_t predict_extend(cmd_t c);
            logic [31:0] rv;
            logic [7:0] b0;
            logic [7:0] b2;
            logic [15:0] lo;
            logic [15:0] hi;
            logic [31:0] value;
            logic ok;
            result_t r;
            case (c.rot_sel)
                ROT_0: rv = c.rm_value;
                ROT_8: rv = {c.rm_value[7:0], c.rm_value[31:8]};
                ROT_16: rv = {c.rm_value[15:0], c.rm_value[31:16]};
                default: rv = {c.rm_value[23:0], c.rm_value[31:24]};
            endcase
            b0 = rv[7:0];
            b2 = rv[23:16];
            value = '0;
            ok = 1'b1;
            case (c.func)
                FUNC_SXTAB16:
                begin
                    lo = {{8{b0[7]}}, b0} + c.rn_value[15:0];
                    hi = {{8{b2[7]}}, b2} + c.rn_value[31:16];
                    value = {hi, lo};
                end
                FUNC_UXTAB16:
                begin
                    lo = {8'h00, b0} + c.rn_value[15:0];
                    hi = {8'h00, b2} + c.rn_value[31:16];
                    value = {hi, lo};
                end
                FUNC_SXTB16: value = {{8{b2[7]}}, b2, {8{b0[7]}}, b0};
                FUNC_UXTB16: value = {8'h00, b2, 8'h00, b0};
                FUNC_SXTAB: value = {{24{b0[7]}}, b0} + c.rn_value;
                FUNC_UXTAB: value = {24'h0, b0} + c.rn_value;
                FUNC_SXTB: value = {{24{b0[7]}}, b0};
                FUNC_UXTB: value = {24'h0, b0};
                FUNC_SXTAH: value = {{16{rv[15]}}, rv[15:0]} + c.rn_value;
                FUNC_UXTAH: value = {16'h0, rv[15:0]} + c.rn_value;
                FUNC_SXTH: value = {{16{rv[15]}}, rv[15:0]};
                FUNC_UXTH: value = {16'h0, rv[15:0]};
                default: ok = 1'b0;
            endcase
            if (!ok || !cond_holds(c))
            begin
                value = '0;
                ok = 1'b0;
            end
            r.result_value = value;
            r.result_dest = c.dest_index;
            r.write_enable = ok;
            return r;
        endfunction

        function void note_command(cmd_t c);
            expected_results.push_back(predict_extend(c));
            noted++;
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result value=%h dest=%h we=%b", $time,
                         got.result_value, got.result_dest, got.write_enable);
                failures++;
                return;
            end
            exp = expected_results.pop_front();
            checked++;
            if (got.write_enable === 1'b1)
                written++;
            if (got.result_value !== exp.result_value)
            begin
                $display("%0t: result_value mismatch, expected %h, actual %h", $time,
                         exp.result_value, got.result_value);
                failures++;
            end
            if (got.result_dest !== exp.result_dest)
            begin
                $display("%0t: result_dest mismatch, expected %h, actual %h", $time,
                         exp.result_dest, got.result_dest);
                failures++;
            end
            if (got.write_enable !== exp.write_enable)
            begin
                $display("%0t: write_enable mismatch, expected %b, actual %b", $time,
                         exp.write_enable, got.write_enable);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd = '0;
    logic busy;
    logic result_valid;
    result_t result;
    int cycle_count = 0;
    extend_checker sb = new();

    conditional_extend_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_command(cmd);
            if (result_valid)
                sb.check_result(result);
        end
    end

    task automatic send_command(input cmd_t c);
        cmd <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic [3:0] func, input logic [3:0] cond,
                               input logic [3:0] nzcv, input logic [31:0] rm,
                               input logic [31:0] rn, input logic [1:0] rot,
                               input logic [3:0] dest);
        cmd_t c;
        c.func = func;
        c.cond_code = cond;
        {c.flag_n, c.flag_z, c.flag_c, c.flag_v} = nzcv;
        c.rm_value = rm;
        c.rn_value = rn;
        c.rot_sel = rot;
        c.dest_index = dest;
        send_command(c);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 3))
            0:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    case ($urandom_range(0, 4))
                        0: w[8*k +: 8] = 8'h00;
                        1: w[8*k +: 8] = 8'h7F;
                        2: w[8*k +: 8] = 8'h80;
                        3: w[8*k +: 8] = 8'hFF;
                        default: w[8*k +: 8] = 8'($urandom());
                    endcase
                end
            end
            1: w = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: w = $urandom();
        endcase
        return w;
    endfunction

    function automatic cmd_t random_command();
        cmd_t c;
        if ($urandom_range(0, 9) == 0)
            c.func = 4'($urandom_range(int'(FUNC_UXTH) + 1, 15));
        else
            c.func = 4'($urandom_range(int'(FUNC_SXTAB16), int'(FUNC_UXTH)));
        if ($urandom_range(0, 3) == 0)
            c.cond_code = COND_AL;
        else
            c.cond_code = 4'($urandom_range(0, 15));
        c.flag_n = 1'($urandom_range(0, 1));
        c.flag_z = 1'($urandom_range(0, 1));
        c.flag_c = 1'($urandom_range(0, 1));
        c.flag_v = 1'($urandom_range(0, 1));
        c.rm_value = random_word();
        c.rn_value = random_word();
        c.rot_sel = 2'($urandom_range(0, 3));
        c.dest_index = 4'($urandom_range(0, 15));
        return c;
    endfunction

    initial
    begin
        int sent;
        int burst;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every function code, the undefined ones included, with the condition always true.
        for (int i = 0; i < 16; i++)
            send_fields(4'(i), COND_AL, 4'(i), 32'h8F7F_80FF,
                        i[0] ? 32'hFFFF_FFFF : 32'h0001_8000, 2'(i), 4'(i));
        send_fields(FUNC_SXTAB, COND_NV, 4'hF, 32'h1234_5678, 32'h1, ROT_0, 4'd3);
        send_fields(FUNC_UXTB, COND_EQ, 4'h0, 32'hFFFF_FFFF, 32'h0, ROT_8, 4'd9);
        send_fields(FUNC_UXTAB16, COND_AL, 4'h0, 32'h0, 32'h0, ROT_0, 4'd0);
        send_fields(FUNC_SXTAB16, COND_AL, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ROT_24, 4'd15);
        send_fields(FUNC_SXTAH, COND_GT, 4'h0, 32'h0000_8000, 32'h7FFF_FFFF, ROT_0, 4'd15);
        send_fields(FUNC_UXTAH, COND_LE, 4'h4, 32'hFFFF_0000, 32'hFFFF_FFFF, ROT_16, 4'd7);
        drain();

        sent = 0;
        while (sent < RandomCount)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RandomCount; k++)
            begin
                send_command(random_command());
                sent++;
                if (sent == RandomCount / 2)
                    drain();
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 6));
        end

        drain();
        repeat (PipeDepth + 2) @(posedge clk);
        $display("Checked %0d extend transactions of %0d sent, %0d of them writing back.",
                 sb.checked, sb.noted, sb.written);
        $display("All twelve extend forms, undefined codes and every condition were exercised.");
        if (sb.failures == 0 && sb.expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
